// ===== hdl/direct_access_code_store_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the direct access code store
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIRECT_ACCESS_CODE_STORE_ASSERT_SVH
`define DIRECT_ACCESS_CODE_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DACS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DACS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dacs_pkg.sv =====
// ----------------------------------------------------------------------------
// dacs_pkg
// Sizes, field layout and codes of the direct access code store.
// ----------------------------------------------------------------------------
package dacs_pkg;

  // Store geometry.
  localparam int CHUNK_BITS = 8;
  localparam int CAPACITY   = 1024;
  localparam int LEVELS     = 8;

  // Derived widths.
  localparam int POS_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ADDR_W  = LVL_W + POS_W;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int WORD_W  = CHUNK_BITS + 1 + POS_W;
  localparam int ACC_W   = LEVELS * CHUNK_BITS;
  localparam int SPAN    = LEVELS * CHUNK_BITS;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 64;
  localparam int CMP_W   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Command codes.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

// ===== hdl/direct_access_code_store.sv =====
// ----------------------------------------------------------------------------
// direct_access_code_store
// Store of 64-bit values split into chunks across levels, with append and read.
// ----------------------------------------------------------------------------
// Every request that is carried out runs through all LEVELS steps, one chunk
// and at most one access to the level store per step; the result then passes
// the done state and is loaded into the output register, and the input is
// ready again in the cycle the result is offered. A new request is not taken
// before the last result has left the done state; a result still waiting in
// the output register holds the next request in its last stage until the sink
// takes it. A read feeds the registered read word straight into the next
// address, so the walk advances one level per step; the value is rebuilt in a
// shift register one chunk per cycle. Rejected requests (store full, too many
// chunks, index out of range) go straight to the done state without the steps.
// Continuation marks are qualified by per-level fill counts, so no clearing
// pass follows reset.
module direct_access_code_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [63:0] in_value,
  input  logic [9:0]  in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_read_value,
  output logic [1:0]  out_status
);

  `include "direct_access_code_store_assert.svh"

  localparam int CB = dacs_pkg::CHUNK_BITS;
  localparam logic [dacs_pkg::LVL_W-1:0] LAST_STEP =
    dacs_pkg::LVL_W'(dacs_pkg::LEVELS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic                          cmd_r;
  logic                          live_r;
  logic [dacs_pkg::LVL_W-1:0]    step_r;
  logic [dacs_pkg::VALUE_W-1:0]  val_r;
  logic [dacs_pkg::ACC_W-1:0]    acc_r;
  logic [dacs_pkg::POS_W-1:0]    pos_r;
  logic [dacs_pkg::CNT_W-1:0]    ring_r [dacs_pkg::LEVELS];
  logic [dacs_pkg::CNT_W-1:0]    entry_count_r;
  dacs_pkg::status_t             status_r;
  logic                          out_valid_r;
  logic [63:0]                   out_read_value_r;
  dacs_pkg::status_t             out_status_r;

  logic [dacs_pkg::WORD_W-1:0]   mem [dacs_pkg::DEPTH];
  logic [dacs_pkg::WORD_W-1:0]   rd_q_r;

  // Request decode at the input.
  logic accept;
  logic store_full;
  logic too_many;
  logic out_of_range;
  logic out_load;
  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign store_full   = (entry_count_r == dacs_pkg::CNT_W'(dacs_pkg::CAPACITY));
  assign too_many     = ((in_value >> dacs_pkg::SPAN) != '0);
  assign out_of_range =
    (dacs_pkg::CMP_W'(in_index) >= dacs_pkg::CMP_W'(entry_count_r));
  assign out_load     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Append step: the low chunk goes to the end of the current level.
  logic [CB-1:0]                 cur_chunk;
  logic                          more;
  logic [dacs_pkg::POS_W-1:0]    app_link;
  logic                          app_we;
  logic [dacs_pkg::ADDR_W-1:0]   wr_addr;
  logic [dacs_pkg::WORD_W-1:0]   wr_data;
  assign cur_chunk = val_r[CB-1:0];
  assign more      = ((val_r >> CB) != '0);
  assign app_link  = more ? ring_r[1][dacs_pkg::POS_W-1:0] : '0;
  assign app_we    = (state_r == S_RUN) && (cmd_r == dacs_pkg::CMD_APPEND) && live_r;
  assign wr_addr   = {step_r, ring_r[0][dacs_pkg::POS_W-1:0]};
  assign wr_data   = {app_link, more, cur_chunk};

  // Read step: the mark only counts inside the filled part of the level.
  logic [CB-1:0]                 rd_chunk;
  logic                          rd_mark;
  logic [dacs_pkg::POS_W-1:0]    rd_link;
  logic                          rd_walk;
  logic                          rd_follow;
  logic                          rd_start;
  logic                          rd_en;
  logic [dacs_pkg::ADDR_W-1:0]   rd_addr;
  assign rd_chunk  = rd_q_r[CB-1:0];
  assign rd_mark   = rd_q_r[CB] && (dacs_pkg::CNT_W'(pos_r) < ring_r[0]);
  assign rd_link   = rd_q_r[dacs_pkg::WORD_W-1:CB+1];
  assign rd_walk   = (state_r == S_RUN) && (cmd_r == dacs_pkg::CMD_READ) && live_r;
  assign rd_follow = rd_walk && rd_mark && (step_r != LAST_STEP);
  assign rd_start  = accept && (in_command == dacs_pkg::CMD_READ) && !out_of_range;
  assign rd_en     = rd_start || rd_follow;
  assign rd_addr   = rd_start ? {dacs_pkg::LVL_W'(0), dacs_pkg::POS_W'(in_index)}
                              : {step_r + 1'b1, rd_link};

  // Rebuilt value shifts right one chunk a step; the chunk enters at the top.
  logic [dacs_pkg::ACC_W-1:0]    acc_nxt;
  logic [dacs_pkg::ACC_W+63:0]   acc_wide;
  assign acc_nxt  = {(rd_walk ? rd_chunk : CB'(0)), acc_r[dacs_pkg::ACC_W-1:CB]};
  assign acc_wide = {64'd0, acc_r};

  // Level store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (app_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Sequencer, fill counts and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      live_r        <= 1'b0;
      step_r        <= '0;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < dacs_pkg::LEVELS; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      // The output register takes a new result or empties once it is taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r  <= in_command;
            val_r  <= in_value;
            acc_r  <= '0;
            pos_r  <= dacs_pkg::POS_W'(in_index);
            step_r <= '0;
            live_r <= 1'b1;
            if (in_command == dacs_pkg::CMD_READ && out_of_range) begin
              status_r <= dacs_pkg::ST_RANGE;
              state_r  <= S_DONE;
            end else if (in_command == dacs_pkg::CMD_APPEND &&
                         (store_full || too_many)) begin
              status_r <= dacs_pkg::ST_FULL;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          acc_r <= acc_nxt;
          val_r <= val_r >> CB;
          // The count ring turns once a step so level step_r sits in front.
          for (int i = 0; i < dacs_pkg::LEVELS - 1; i++) begin
            ring_r[i] <= ring_r[i + 1];
          end
          ring_r[dacs_pkg::LEVELS-1] <= app_we ? ring_r[0] + 1'b1 : ring_r[0];
          if (app_we) begin
            live_r <= more;
            if (!more) begin
              entry_count_r <= entry_count_r + 1'b1;
            end
          end else if (rd_walk) begin
            live_r <= rd_follow;
            pos_r  <= rd_link;
          end
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) begin
            status_r <= dacs_pkg::ST_OK;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_read_value_r <= acc_wide[63:0];
            out_status_r     <= status_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;

  // Checks on the sequencer and the fill counts.
  `DACS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "request taken while busy")
  `DACS_ASSERT_SAME(a_count_bound, 1'b1,
    entry_count_r <= dacs_pkg::CNT_W'(dacs_pkg::CAPACITY), "entry count beyond capacity")
  `DACS_ASSERT_SAME(a_no_mark_last, app_we && step_r == LAST_STEP, !more,
    "continuation past the last level")
  `DACS_ASSERT_NEXT(a_result_loaded, out_load, out_valid_r && in_ready,
    "result not delivered")

endmodule
